// ===== rtl/psw_pkg.sv =====
// Shared types and constants for the priority schedule wait-time block.
// Used by the core and its testbench; no dependencies.
`default_nettype none

package psw_pkg;

    localparam int NUM_W   = 7;
    localparam int FIELD_W = 16;
    localparam int TIME_W  = 22;
    localparam int MEAN_W  = 30;
    localparam int FRAC_W  = 8;

    typedef struct packed {
        logic [FIELD_W-1:0] burst_time;
        logic [FIELD_W-1:0] priority_level;
        logic               last_job;
    } t_in_beat;

    typedef struct packed {
        logic [NUM_W-1:0]   job_number;
        logic [FIELD_W-1:0] job_burst;
        logic [FIELD_W-1:0] job_priority;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  finish_time;
        logic [MEAN_W-1:0]  mean_wait_fx;
        logic [MEAN_W-1:0]  mean_finish_fx;
        logic               final_result;
        logic               capacity_exceeded;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_RD,
        ST_SORT_KEY,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_SUM_RD,
        ST_SUM,
        ST_DIVW_GO,
        ST_DIVW_RUN,
        ST_DIVF_GO,
        ST_DIVF_RUN,
        ST_OUT_RD,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/psw_store.sv =====
// Job store: one write port, one read port with registered read data.
// No package dependencies.
`default_nettype none

module psw_store #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/psw_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No package dependencies.
`default_nettype none

module psw_div #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_d, n_d;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_rem, r_q[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_d};
    assign ge     = rem_sh >= {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DVD_W);
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DVD_W-2:0], ge};
            n_rem = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

// ===== rtl/priority_schedule_wait_times_core.sv =====
// Non-preemptive priority scheduler: loads jobs, sorts them by priority and
// reports wait and finish times. Depends on psw_pkg, psw_store and psw_div.
//
// Jobs load one beat per cycle while busy is low; a beat with a zero burst or
// zero priority is ignored except for its last flag. After the last beat the
// block raises busy, unless no job was stored, and works through n stored
// jobs: an insertion sort over the store (skipped for a single job), a
// prefix-sum pass, two averages on one shared bit-serial divider, then n
// results on consecutive cycles, each marked by o_strobe for one cycle.
// The receiver cannot stall; busy drops with the last result.
`default_nettype none

module priority_schedule_wait_times_core #(
    parameter int MAX_JOBS      = 64,
    parameter int BURST_BITS    = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire psw_pkg::t_in_beat    i_job,
    output logic                      o_strobe,
    output psw_pkg::t_out_beat        o_result
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int ENT_W = psw_pkg::NUM_W + PRIORITY_BITS + BURST_BITS;
    localparam int ACC_W = BURST_BITS + CNT_W;
    localparam int SUM_W = BURST_BITS + 2 * CNT_W;
    localparam int DVD_W = SUM_W + psw_pkg::FRAC_W;
    localparam int P_LO  = BURST_BITS;
    localparam int N_LO  = BURST_BITS + PRIORITY_BITS;

    psw_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_dropped, n_dropped;
    logic [CNT_W-1:0]          r_i, n_i;
    logic [IDX_W-1:0]          r_j, n_j;
    logic [ENT_W-1:0]          r_key, n_key;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic [SUM_W-1:0]          r_sum_w, n_sum_w;
    logic [psw_pkg::MEAN_W-1:0] r_mean_w, n_mean_w;
    logic [psw_pkg::MEAN_W-1:0] r_mean_f, n_mean_f;
    logic                      r_strobe, n_strobe;
    psw_pkg::t_out_beat        r_out, n_out;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
    logic [ENT_W-1:0] rdata;

    logic             div_start;
    logic             div_done;
    logic [DVD_W-1:0] div_dividend;
    logic [DVD_W-1:0] div_quot;
    logic [SUM_W-1:0] sum_f;

    logic                     accept;
    logic [BURST_BITS-1:0]    in_burst;
    logic [PRIORITY_BITS-1:0] in_prio;
    logic                     in_valid;
    logic                     room;
    logic [CNT_W-1:0]         count_after;
    logic [CNT_W-1:0]         i_next;
    logic [BURST_BITS-1:0]    rd_burst;

    psw_store #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_JOBS),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    psw_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign busy        = (r_state != psw_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign in_burst    = BURST_BITS'(i_job.burst_time);
    assign in_prio     = PRIORITY_BITS'(i_job.priority_level);
    assign in_valid    = (in_burst != '0) && (in_prio != '0);
    assign room        = (r_count < CNT_W'(MAX_JOBS));
    assign count_after = r_count + CNT_W'(in_valid && room);
    assign i_next      = r_i + CNT_W'(1);
    assign rd_burst    = rdata[BURST_BITS-1:0];
    assign sum_f       = r_sum_w + SUM_W'(r_acc);
    assign div_dividend = (r_state == psw_pkg::ST_DIVW_GO) ?
                          {r_sum_w, psw_pkg::FRAC_W'(0)} : {sum_f, psw_pkg::FRAC_W'(0)};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_i       = r_i;
        n_j       = r_j;
        n_key     = r_key;
        n_acc     = r_acc;
        n_sum_w   = r_sum_w;
        n_mean_w  = r_mean_w;
        n_mean_f  = r_mean_f;
        n_strobe  = 1'b0;
        n_out     = r_out;
        we        = 1'b0;
        waddr     = r_j;
        wdata     = r_key;
        raddr     = '0;
        div_start = 1'b0;
        unique case (r_state)
            psw_pkg::ST_IDLE: begin
                waddr = r_count[IDX_W-1:0];
                wdata = {psw_pkg::NUM_W'(r_count + CNT_W'(1)), in_prio, in_burst};
                if (accept) begin
                    we        = in_valid && room;
                    n_count   = count_after;
                    n_dropped = r_dropped || (in_valid && !room);
                    if (i_job.last_job) begin
                        n_i = CNT_W'(1);
                        if (count_after == '0) begin
                            n_dropped = 1'b0;
                        end else if (count_after == CNT_W'(1)) begin
                            n_state = psw_pkg::ST_SUM_RD;
                        end else begin
                            n_state = psw_pkg::ST_SORT_RD;
                        end
                    end
                end
            end
            psw_pkg::ST_SORT_RD: begin
                raddr   = r_i[IDX_W-1:0];
                n_state = psw_pkg::ST_SORT_KEY;
            end
            psw_pkg::ST_SORT_KEY: begin
                n_key   = rdata;
                n_j     = r_i[IDX_W-1:0];
                raddr   = r_i[IDX_W-1:0] - IDX_W'(1);
                n_state = psw_pkg::ST_SORT_CMP;
            end
            psw_pkg::ST_SORT_CMP: begin
                if (rdata[N_LO-1:P_LO] > r_key[N_LO-1:P_LO]) begin
                    we    = 1'b1;
                    waddr = r_j;
                    wdata = rdata;
                    n_j   = r_j - IDX_W'(1);
                    if (r_j == IDX_W'(1)) begin
                        n_state = psw_pkg::ST_SORT_PUT;
                    end else begin
                        raddr = r_j - IDX_W'(2);
                    end
                end else begin
                    n_state = psw_pkg::ST_SORT_PUT;
                end
            end
            psw_pkg::ST_SORT_PUT: begin
                we  = 1'b1;
                n_i = i_next;
                if (i_next == r_count) begin
                    n_state = psw_pkg::ST_SUM_RD;
                end else begin
                    raddr   = i_next[IDX_W-1:0];
                    n_state = psw_pkg::ST_SORT_KEY;
                end
            end
            psw_pkg::ST_SUM_RD: begin
                raddr   = '0;
                n_i     = '0;
                n_acc   = '0;
                n_sum_w = '0;
                n_state = psw_pkg::ST_SUM;
            end
            psw_pkg::ST_SUM: begin
                n_sum_w = r_sum_w + SUM_W'(r_acc);
                n_acc   = r_acc + ACC_W'(rd_burst);
                n_i     = i_next;
                if (i_next == r_count) begin
                    n_state = psw_pkg::ST_DIVW_GO;
                end else begin
                    raddr = i_next[IDX_W-1:0];
                end
            end
            psw_pkg::ST_DIVW_GO: begin
                div_start = 1'b1;
                n_state   = psw_pkg::ST_DIVW_RUN;
            end
            psw_pkg::ST_DIVW_RUN: begin
                if (div_done) begin
                    n_mean_w = psw_pkg::MEAN_W'(div_quot);
                    n_state  = psw_pkg::ST_DIVF_GO;
                end
            end
            psw_pkg::ST_DIVF_GO: begin
                div_start = 1'b1;
                n_state   = psw_pkg::ST_DIVF_RUN;
            end
            psw_pkg::ST_DIVF_RUN: begin
                if (div_done) begin
                    n_mean_f = psw_pkg::MEAN_W'(div_quot);
                    n_state  = psw_pkg::ST_OUT_RD;
                end
            end
            psw_pkg::ST_OUT_RD: begin
                raddr   = '0;
                n_i     = '0;
                n_acc   = '0;
                n_state = psw_pkg::ST_OUT;
            end
            psw_pkg::ST_OUT: begin
                n_strobe                = 1'b1;
                n_out.job_number        = rdata[ENT_W-1:N_LO];
                n_out.job_burst         = psw_pkg::FIELD_W'(rd_burst);
                n_out.job_priority      = psw_pkg::FIELD_W'(rdata[N_LO-1:P_LO]);
                n_out.wait_time         = psw_pkg::TIME_W'(r_acc);
                n_out.finish_time       = psw_pkg::TIME_W'(r_acc + ACC_W'(rd_burst));
                n_out.mean_wait_fx      = r_mean_w;
                n_out.mean_finish_fx    = r_mean_f;
                n_out.final_result      = (i_next == r_count);
                n_out.capacity_exceeded = r_dropped;
                n_acc                   = r_acc + ACC_W'(rd_burst);
                n_i                     = i_next;
                if (i_next == r_count) begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                    n_state   = psw_pkg::ST_IDLE;
                end else begin
                    raddr = i_next[IDX_W-1:0];
                end
            end
            default: begin
                n_state = psw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psw_pkg::ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_key    <= n_key;
        r_acc    <= n_acc;
        r_sum_w  <= n_sum_w;
        r_mean_w <= n_mean_w;
        r_mean_f <= n_mean_f;
        r_out    <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== tb/tb_priority_schedule_wait_times_core.sv =====
// Testbench for priority_schedule_wait_times_core: drives job beats, predicts each
// batch schedule in place and checks every result beat field by field.
// Depends on psw_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_priority_schedule_wait_times_core;

    import psw_pkg::*;

    localparam int          MAX_JOBS      = 64;
    localparam int          BURST_BITS    = 16;
    localparam int          PRIORITY_BITS = 16;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          DRAIN_CYCLES  = 3000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_beat  i_job   = '0;
    logic      busy;
    logic      o_strobe;
    t_out_beat o_result;

    priority_schedule_wait_times_core #(
        .MAX_JOBS      (MAX_JOBS),
        .BURST_BITS    (BURST_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_job    (i_job),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    logic [BURST_BITS-1:0]    job_burst_q [MAX_JOBS];
    logic [PRIORITY_BITS-1:0] job_prio_q  [MAX_JOBS];
    logic [NUM_W-1:0]         job_num_q   [MAX_JOBS];
    int unsigned              jobs_loaded = 0;
    logic [NUM_W-1:0]         next_job_num = 1;
    logic                     overflow_seen = 1'b0;

    t_out_beat   schedule_q [$];
    t_out_beat   want_beat;
    int          fail_count  = 0;
    int          idle_pct    = 0;
    int unsigned cycle_count = 0;

    function automatic void restart_batch();
        jobs_loaded   = 0;
        next_job_num  = 1;
        overflow_seen = 1'b0;
    endfunction

    function automatic void schedule_beat(input t_in_beat b);
        logic [BURST_BITS-1:0]    bv;
        logic [PRIORITY_BITS-1:0] pv;
        logic [BURST_BITS-1:0]    kb;
        logic [PRIORITY_BITS-1:0] kp;
        logic [NUM_W-1:0]         kn;
        logic [63:0]              acc;
        logic [63:0]              sum_w;
        logic [63:0]              sum_f;
        logic [63:0]              mean_w;
        logic [63:0]              mean_f;
        logic [63:0]              n64;
        logic [63:0]              fin;
        int                       i;
        int                       j;
        t_out_beat                r;
        bv = b.burst_time[BURST_BITS-1:0];
        pv = b.priority_level[PRIORITY_BITS-1:0];
        if (bv != 0 && pv != 0) begin
            if (jobs_loaded < MAX_JOBS) begin
                job_burst_q[jobs_loaded] = bv;
                job_prio_q[jobs_loaded]  = pv;
                job_num_q[jobs_loaded]   = next_job_num;
                jobs_loaded++;
                next_job_num++;
            end else begin
                overflow_seen = 1'b1;
            end
        end
        if (!b.last_job) return;
        if (jobs_loaded == 0) begin
            restart_batch();
            return;
        end
        // stable insertion sort, ascending priority value
        for (i = 1; i < jobs_loaded; i++) begin
            kb = job_burst_q[i];
            kp = job_prio_q[i];
            kn = job_num_q[i];
            j  = i;
            while (j > 0 && job_prio_q[j-1] > kp) begin
                job_burst_q[j] = job_burst_q[j-1];
                job_prio_q[j]  = job_prio_q[j-1];
                job_num_q[j]   = job_num_q[j-1];
                j--;
            end
            job_burst_q[j] = kb;
            job_prio_q[j]  = kp;
            job_num_q[j]   = kn;
        end
        acc   = 0;
        sum_w = 0;
        sum_f = 0;
        for (i = 0; i < jobs_loaded; i++) begin
            sum_w += acc;
            acc   += job_burst_q[i];
            sum_f += acc;
        end
        n64    = jobs_loaded;
        mean_w = (sum_w << FRAC_W) / n64;
        mean_f = (sum_f << FRAC_W) / n64;
        acc    = 0;
        for (i = 0; i < jobs_loaded; i++) begin
            fin                 = acc + job_burst_q[i];
            r.job_number        = job_num_q[i];
            r.job_burst         = job_burst_q[i];
            r.job_priority      = job_prio_q[i];
            r.wait_time         = acc[TIME_W-1:0];
            r.finish_time       = fin[TIME_W-1:0];
            r.mean_wait_fx      = mean_w[MEAN_W-1:0];
            r.mean_finish_fx    = mean_f[MEAN_W-1:0];
            r.final_result      = (i == jobs_loaded - 1);
            r.capacity_exceeded = overflow_seen;
            schedule_q.push_back(r);
            acc = fin;
        end
        restart_batch();
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (schedule_q.size() == 0) begin
                    $error("result beat with none pending: job_number %0d",
                           o_result.job_number);
                    fail_count++;
                end else begin
                    want_beat = schedule_q.pop_front();
                    check_field("job_number", want_beat.job_number, o_result.job_number);
                    check_field("job_burst", want_beat.job_burst, o_result.job_burst);
                    check_field("job_priority", want_beat.job_priority,
                                o_result.job_priority);
                    check_field("wait_time", want_beat.wait_time, o_result.wait_time);
                    check_field("finish_time", want_beat.finish_time, o_result.finish_time);
                    check_field("mean_wait_fx", want_beat.mean_wait_fx,
                                o_result.mean_wait_fx);
                    check_field("mean_finish_fx", want_beat.mean_finish_fx,
                                o_result.mean_finish_fx);
                    check_field("final_result", want_beat.final_result,
                                o_result.final_result);
                    check_field("capacity_exceeded", want_beat.capacity_exceeded,
                                o_result.capacity_exceeded);
                end
            end
            if (start && !busy) schedule_beat(i_job);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_priority_schedule_wait_times_core NOT OK");
            $finish;
        end
    end

    function automatic t_in_beat mk_beat(input logic [FIELD_W-1:0] bt,
                                         input logic [FIELD_W-1:0] pl, input logic lj);
        t_in_beat b;
        b.burst_time     = bt;
        b.priority_level = pl;
        b.last_job       = lj;
        return b;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_field(input int tie_pct);
        int r;
        r = $urandom_range(99);
        if (r < tie_pct) return FIELD_W'($urandom_range(1, 4));
        if (r < tie_pct + 5) return '1;
        return FIELD_W'($urandom_range(1, 65535));
    endfunction

    // Called right after a rising edge; returns right after the edge that takes the beat.
    task automatic send_beat(input t_in_beat b);
        logic busy_seen;
        int   gap;
        int   k;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 16) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            for (k = 0; k < gap; k++) begin
                i_job <= mk_beat(FIELD_W'($urandom_range(65535)),
                                 FIELD_W'($urandom_range(65535)), 1'($urandom_range(1)));
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_job <= b;
        do begin
            @(negedge i_clk);
            busy_seen = busy;
            @(posedge i_clk);
        end while (busy_seen);
    endtask

    task automatic test_field_extremes();
        send_beat(mk_beat(16'hFFFF, 16'hFFFF, 1'b0));
        send_beat(mk_beat(16'h0001, 16'h0001, 1'b0));
        send_beat(mk_beat(16'hFFFF, 16'h0001, 1'b0));
        send_beat(mk_beat(16'h0001, 16'hFFFF, 1'b1));
    endtask

    task automatic test_rejected_beats();
        send_beat(mk_beat(16'd0, 16'd5, 1'b0));
        send_beat(mk_beat(16'd7, 16'd3, 1'b0));
        send_beat(mk_beat(16'd9, 16'd0, 1'b0));
        send_beat(mk_beat(16'd0, 16'd0, 1'b0));
        send_beat(mk_beat(16'd4, 16'd2, 1'b0));
        send_beat(mk_beat(16'd0, 16'd1, 1'b1));
    endtask

    task automatic test_priority_ties();
        send_beat(mk_beat(16'd10, 16'd3, 1'b0));
        send_beat(mk_beat(16'd20, 16'd3, 1'b0));
        send_beat(mk_beat(16'd5, 16'd1, 1'b0));
        send_beat(mk_beat(16'd30, 16'd3, 1'b0));
        send_beat(mk_beat(16'd15, 16'd1, 1'b1));
    endtask

    task automatic test_empty_schedule();
        send_beat(mk_beat(16'd0, 16'd9, 1'b1));
        send_beat(mk_beat(16'd0, 16'd0, 1'b1));
        send_beat(mk_beat(16'd8, 16'd8, 1'b1));
    endtask

    task automatic test_store_overflow(input bit max_bursts, input int extra);
        int k;
        for (k = 0; k < MAX_JOBS; k++) begin
            send_beat(mk_beat(max_bursts ? 16'hFFFF : pick_field(10), pick_field(30),
                              extra == 0 && k == MAX_JOBS - 1));
        end
        // odd extras are rejected, even extras are valid and dropped
        for (k = 0; k < extra; k++) begin
            if (k % 2 == 1) begin
                send_beat(mk_beat(16'd0, pick_field(30), k == extra - 1));
            end else begin
                send_beat(mk_beat(pick_field(10), pick_field(30), k == extra - 1));
            end
        end
    endtask

    task automatic test_random_batches(input int unsigned n_items);
        int unsigned sent;
        int          size;
        int          k;
        int          kind;
        logic        lj;
        sent = 0;
        while (sent < n_items) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (k = 0; k < size; k++) begin
                kind = $urandom_range(99);
                lj   = (k == size - 1);
                if (kind < 8) begin
                    send_beat(mk_beat(16'd0, FIELD_W'($urandom_range(65535)), lj));
                end else if (kind < 14) begin
                    send_beat(mk_beat(FIELD_W'($urandom_range(65535)), 16'd0, lj));
                end else begin
                    send_beat(mk_beat(pick_field(10), pick_field(40), lj));
                end
                sent++;
            end
        end
    endtask

    initial begin
        restart_batch();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 33;
        test_field_extremes();
        test_rejected_beats();
        test_priority_ties();
        test_empty_schedule();
        test_random_batches(70);

        idle_pct = 46;
        test_store_overflow(1'b1, 3);
        test_random_batches(70);

        idle_pct = 0;
        test_store_overflow(1'b0, 0);
        test_random_batches(70);

        start <= 1'b0;
        while (schedule_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_priority_schedule_wait_times_core OK");
        end else begin
            $display("tb_priority_schedule_wait_times_core NOT OK");
        end
        $finish;
    end

endmodule
